/* rtl/scds_pkg.sv */
// Shared types, constants and the microcode program of the serial clock divider search.
package scds_pkg;

  // Field and datapath widths.
  localparam int unsigned ClkW  = 32;
  localparam int unsigned PreW  = 8;
  localparam int unsigned PostW = 9;
  localparam int unsigned IncW  = 41;
  localparam int unsigned AccW  = 50;
  localparam int unsigned DvsW  = PreW + PostW;
  localparam int unsigned RemW  = DvsW + 1;
  localparam int unsigned CntW  = 6;
  localparam int unsigned PcW   = 4;

  // Fixed values of the search.
  localparam logic [ClkW-1:0]  ClkResetHz = 32'd125000000;
  localparam logic [PreW-1:0]  PreMin     = 8'd2;
  localparam logic [PreW-1:0]  PreMax     = 8'd254;
  localparam logic [PostW-1:0] PostMax    = 9'd256;
  localparam logic [PostW-1:0] PostMin    = 9'd1;

  // Step addresses of the program.
  localparam logic [PcW-1:0] StIdle     = 4'd0;
  localparam logic [PcW-1:0] StPreInit  = 4'd1;
  localparam logic [PcW-1:0] StPreLoop  = 4'd2;
  localparam logic [PcW-1:0] StMulA     = 4'd3;
  localparam logic [PcW-1:0] StPostInit = 4'd4;
  localparam logic [PcW-1:0] StPostLoop = 4'd5;
  localparam logic [PcW-1:0] StDivInit  = 4'd6;
  localparam logic [PcW-1:0] StDivLoop  = 4'd7;
  localparam logic [PcW-1:0] StEmit     = 4'd8;
  localparam logic [PcW-1:0] StSpecial  = 4'd9;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_REQ,
    OP_LOAD_PRE,
    OP_PRE_STEP,
    OP_MUL_A,
    OP_LOAD_POST,
    OP_POST_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT,
    OP_SPECIAL
  } op_e;

  // Branch conditions.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_VALID,
    C_REQ_GT_CLK,
    C_PRE_DONE,
    C_POST_DONE,
    C_DIV_DONE,
    C_OUT_FREE
  } cond_e;

  // One control word: the operation runs when the condition equals exec_on.
  // A true condition jumps to target; otherwise the step repeats (loop) or
  // falls through to the next address.
  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic           exec_on;
    logic           loop;
    logic           accept;
    logic [PcW-1:0] target;
  } uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic req_gt_clk;
    logic pre_done;
    logic post_done;
    logic div_done;
    logic out_free;
  } status_t;

  // Program store.
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, exec_on: 1'b0, loop: 1'b0, accept: 1'b0,
          target: StIdle};
    unique case (pc)
      StIdle: w = '{op: OP_LOAD_REQ, cond: C_IN_VALID, exec_on: 1'b1, loop: 1'b1,
                    accept: 1'b1, target: StPreInit};
      StPreInit: w = '{op: OP_LOAD_PRE, cond: C_REQ_GT_CLK, exec_on: 1'b0,
                       loop: 1'b0, accept: 1'b0, target: StSpecial};
      StPreLoop: w = '{op: OP_PRE_STEP, cond: C_PRE_DONE, exec_on: 1'b0,
                       loop: 1'b1, accept: 1'b0, target: StMulA};
      StMulA: w = '{op: OP_MUL_A, cond: C_NEVER, exec_on: 1'b0, loop: 1'b0,
                    accept: 1'b0, target: StIdle};
      StPostInit: w = '{op: OP_LOAD_POST, cond: C_NEVER, exec_on: 1'b0, loop: 1'b0,
                        accept: 1'b0, target: StIdle};
      StPostLoop: w = '{op: OP_POST_STEP, cond: C_POST_DONE, exec_on: 1'b0,
                        loop: 1'b1, accept: 1'b0, target: StDivInit};
      StDivInit: w = '{op: OP_DIV_INIT, cond: C_NEVER, exec_on: 1'b0, loop: 1'b0,
                       accept: 1'b0, target: StIdle};
      StDivLoop: w = '{op: OP_DIV_STEP, cond: C_DIV_DONE, exec_on: 1'b0,
                       loop: 1'b1, accept: 1'b0, target: StEmit};
      StEmit: w = '{op: OP_EMIT, cond: C_OUT_FREE, exec_on: 1'b1, loop: 1'b1,
                    accept: 1'b0, target: StIdle};
      StSpecial: w = '{op: OP_SPECIAL, cond: C_ALWAYS, exec_on: 1'b1, loop: 1'b0,
                       accept: 1'b0, target: StEmit};
      default: w = '{op: OP_NOP, cond: C_ALWAYS, exec_on: 1'b0, loop: 1'b0,
                     accept: 1'b0, target: StIdle};
    endcase
    return w;
  endfunction

endpackage

/* rtl/spi_clock_divider_search.sv */
// Top level of the serial clock divider search.
//
//   Channel  Direction  Handshake                 Payload
//   cfg      in         cfg_we_i                  cfg_wdata_i (peripheral clock, Hz)
//   in       in         in_valid_i / in_ready_o   requested_rate_hz_i
//   out      out        out_valid_o / out_ready_i prescale_value_o, post_divide_o,
//                                                 actual_rate_hz_o
//
// From transfer to result an item runs through P prescale steps (P 0..126) and
// D postdivide steps (D 0..255); a request above the clock skips the loops and the divider.
// The prescale and postdivide loops and the 32-step restoring divider are all run
// by the microcode sequencer one step per cycle.
// Reset loads the clock register with 125 MHz and returns the sequencer to idle.
// A new item is taken while an earlier result still waits on the output.
module spi_clock_divider_search import scds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ClkW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ClkW-1:0]   requested_rate_hz_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PreW-1:0]   prescale_value_o,
  output logic [PostW-1:0]  post_divide_o,
  output logic [ClkW-1:0]   actual_rate_hz_o
);

  logic [ClkW-1:0] clock_hz_q;
  status_t         status;
  op_e             op;

  // Peripheral clock register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= ClkResetHz;
    end else if (cfg_we_i) begin
      clock_hz_q <= cfg_wdata_i;
    end
  end

  // Microcode sequencer.
  scds_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .op_o       (op)
  );

  // Datapath and result register.
  scds_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .op_i                (op),
    .clock_hz_i          (clock_hz_q),
    .requested_rate_hz_i (requested_rate_hz_i),
    .out_ready_i         (out_ready_i),
    .status_o            (status),
    .out_valid_o         (out_valid_o),
    .prescale_value_o    (prescale_value_o),
    .post_divide_o       (post_divide_o),
    .actual_rate_hz_o    (actual_rate_hz_o)
  );

endmodule

/* rtl/scds_sequencer.sv */
// Step counter, program lookup and conditional branching of the divider search.
module scds_sequencer import scds_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output op_e     op_o
);

  logic [PcW-1:0] pc_q, pc_d;
  uword_t         word;
  logic           cond_hit;

  // Current control word.
  assign word = ucode(pc_q);

  // Condition select.
  always_comb begin
    unique case (word.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_ALWAYS:     cond_hit = 1'b1;
      C_IN_VALID:   cond_hit = in_valid_i;
      C_REQ_GT_CLK: cond_hit = status_i.req_gt_clk;
      C_PRE_DONE:   cond_hit = status_i.pre_done;
      C_POST_DONE:  cond_hit = status_i.post_done;
      C_DIV_DONE:   cond_hit = status_i.div_done;
      C_OUT_FREE:   cond_hit = status_i.out_free;
      default:      cond_hit = 1'b0;
    endcase
  end

  // Operation issue and input handshake.
  assign op_o       = (cond_hit == word.exec_on) ? word.op : OP_NOP;
  assign in_ready_o = word.accept;

  // Next step address.
  always_comb begin
    if (cond_hit) begin
      pc_d = word.target;
    end else if (word.loop) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* rtl/scds_datapath.sv */
// Datapath of the divider search: accumulators, divider and result register.
module scds_datapath import scds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  op_e               op_i,
  input  logic [ClkW-1:0]   clock_hz_i,
  input  logic [ClkW-1:0]   requested_rate_hz_i,
  input  logic              out_ready_i,
  output status_t           status_o,
  output logic              out_valid_o,
  output logic [PreW-1:0]   prescale_value_o,
  output logic [PostW-1:0]  post_divide_o,
  output logic [ClkW-1:0]   actual_rate_hz_o
);

  logic [ClkW-1:0]  req_q;
  logic [PreW-1:0]  pre_q;
  logic [PostW-1:0] post_q;
  logic [AccW-1:0]  acc_q;
  logic [IncW-1:0]  inc_q;
  logic [DvsW-1:0]  dvs_q;
  logic [RemW-1:0]  rem_q;
  logic [ClkW-1:0]  quo_q;
  logic [CntW-1:0]  cnt_q;
  logic             out_valid_q;
  logic [PreW-1:0]  out_pre_q;
  logic [PostW-1:0] out_post_q;
  logic [ClkW-1:0]  out_rate_q;

  logic [ClkW:0]    req_p1;
  logic [IncW-1:0]  mul_a;
  logic [DvsW-1:0]  dvs_mul;
  logic [AccW-1:0]  clk_ext;
  logic [AccW-1:0]  inc_ext;
  logic [RemW-1:0]  rem_sh;
  logic             rem_ge;
  logic [RemW-1:0]  rem_sub;

  // Product (request + 1) * prescale gives the postdivide test step.
  assign req_p1  = {1'b0, req_q} + (ClkW+1)'(1);
  assign mul_a   = {(IncW-ClkW-1)'(0), req_p1} * {(IncW-PreW)'(0), pre_q};
  assign dvs_mul = {(DvsW-PreW)'(0), pre_q} * {(DvsW-PostW)'(0), post_q};
  assign clk_ext = {(AccW-ClkW)'(0), clock_hz_i};
  assign inc_ext = {(AccW-IncW)'(0), inc_q};

  // One restoring division step.
  assign rem_sh  = {rem_q[RemW-2:0], quo_q[ClkW-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // Status for the branch conditions.
  assign status_o.req_gt_clk = req_q > clock_hz_i;
  assign status_o.pre_done   = (clk_ext < acc_q) || (pre_q == PreMax);
  assign status_o.post_done  = clk_ext >= acc_q;
  assign status_o.div_done   = cnt_q == CntW'(ClkW);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Working registers, steered by the current operation.
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD_REQ: begin
        req_q <= requested_rate_hz_i;
      end
      OP_LOAD_PRE: begin
        // Reach for prescale 2 is 4 * 256 * request; each step adds 2 * 256 * request.
        pre_q <= PreMin;
        acc_q <= {(AccW-ClkW-10)'(0), req_q, 10'd0};
        inc_q <= {req_q, 9'd0};
      end
      OP_PRE_STEP: begin
        pre_q <= pre_q + PreW'(2);
        acc_q <= acc_q + inc_ext;
      end
      OP_MUL_A: begin
        inc_q <= mul_a;
      end
      OP_LOAD_POST: begin
        // Threshold for postdivide d is (request + 1) * prescale * (d - 1).
        post_q <= PostMax;
        acc_q  <= {inc_ext[AccW-9:0], 8'd0} - inc_ext;
      end
      OP_POST_STEP: begin
        post_q <= post_q - PostW'(1);
        acc_q  <= acc_q - inc_ext;
      end
      OP_DIV_INIT: begin
        dvs_q <= dvs_mul;
        rem_q <= '0;
        quo_q <= clock_hz_i;
        cnt_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= rem_ge ? rem_sub : rem_sh;
        quo_q <= {quo_q[ClkW-2:0], rem_ge};
        cnt_q <= cnt_q + CntW'(1);
      end
      OP_SPECIAL: begin
        pre_q  <= PreMin;
        post_q <= PostMin;
        quo_q  <= clock_hz_i;
      end
      OP_EMIT: begin
        out_pre_q  <= pre_q;
        out_post_q <= post_q;
        out_rate_q <= quo_q;
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign prescale_value_o = out_pre_q;
  assign post_divide_o    = out_post_q;
  assign actual_rate_hz_o = out_rate_q;

endmodule

/* bench/tb_spi_clock_divider_search.sv */
// Self-checking testbench for the serial clock divider search block.
module tb_spi_clock_divider_search import scds_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned SettleCycles  = 450;
  localparam int unsigned ItemsPerPhase = 55;
  localparam int unsigned NumPhases     = 7;

  // Tracks the clock register and the divisor settings still owed by the block.
  class divider_scoreboard;
    typedef struct packed {
      logic [PreW-1:0]  pre;
      logic [PostW-1:0] post;
      logic [ClkW-1:0]  rate;
    } divisors_t;

    logic [ClkW-1:0] clk_hz;
    divisors_t       owed_q[$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     above_clock;
    int unsigned     pre_max;
    int unsigned     post_one;

    function new();
      clk_hz      = ClkResetHz;
      mismatches  = 0;
      checked     = 0;
      above_clock = 0;
      pre_max     = 0;
      post_one    = 0;
    endfunction

    function void set_clock(logic [ClkW-1:0] hz);
      clk_hz = hz;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Works out the divisors that the search settles on for one request.
    function divisors_t divisors_for(logic [ClkW-1:0] req);
      divisors_t       d;
      logic [63:0]     reach;
      logic [ClkW-1:0] step_div;
      logic            found;
      int              p;
      int              q;
      d.pre  = PreMax;
      d.post = PostMin;
      d.rate = clk_hz;
      if (req > clk_hz) begin
        d.pre  = PreMin;
        d.post = PostMin;
        return d;
      end
      // Smallest even prescale that brings the clock within reach of the post divider.
      found = 1'b0;
      for (p = int'(PreMin); p <= int'(PreMax) && !found; p += 2) begin
        reach = 64'(p + 2) * 64'd256 * 64'(req);
        if (64'(clk_hz) < reach) begin
          d.pre = p[PreW-1:0];
          found = 1'b1;
        end
      end
      // Largest post divider whose next lower step would still run too fast.
      found = 1'b0;
      for (q = int'(PostMax); q > 1 && !found; q--) begin
        step_div = 32'(d.pre) * 32'(q - 1);
        if (clk_hz / step_div > req) begin
          d.post = q[PostW-1:0];
          found  = 1'b1;
        end
      end
      d.rate = clk_hz / (32'(d.pre) * 32'(d.post));
      return d;
    endfunction

    // Records a request taken by the block.
    function void note_request(logic [ClkW-1:0] req);
      divisors_t d;
      d = divisors_for(req);
      if (req > clk_hz) above_clock++;
      if (d.pre == PreMax) pre_max++;
      if (d.post == PostMin) post_one++;
      owed_q.push_back(d);
    endfunction

    // Compares one delivered result with the oldest owed setting.
    function void check_result(logic [PreW-1:0] pre, logic [PostW-1:0] post,
                               logic [ClkW-1:0] rate);
      divisors_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with nothing owed: prescale %0d post %0d rate %0d",
                 $time, pre, post, rate);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (pre !== want.pre) begin
        $display("%0t: prescale mismatch, expected %0d, actual %0d", $time, want.pre, pre);
        mismatches++;
      end
      if (post !== want.post) begin
        $display("%0t: post divide mismatch, expected %0d, actual %0d",
                 $time, want.post, post);
        mismatches++;
      end
      if (rate !== want.rate) begin
        $display("%0t: actual rate mismatch, expected %0d, actual %0d",
                 $time, want.rate, rate);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we      = 1'b0;
  logic [ClkW-1:0]   cfg_wdata   = '0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [ClkW-1:0]   in_rate     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [PreW-1:0]   prescale;
  logic [PostW-1:0]  post_divide;
  logic [ClkW-1:0]   actual_rate;

  divider_scoreboard sb = new();
  logic              idle_on    = 1'b1;
  int unsigned       stall_left = 0;
  int unsigned       cycles     = 0;
  int unsigned       settings   = 1;
  logic [ClkW-1:0]   phase_clocks [NumPhases];
  logic [ClkW-1:0]   directed_rates [$] = '{
    32'd0, 32'd1, 32'd1000, 32'd1922, 32'd1923, 32'd244140, 32'd244141,
    32'd400000, 32'd1000000, 32'd10000000, 32'd31250000, 32'd62499999,
    32'd62500000, 32'd62500001, 32'd100000000, 32'd124999999, 32'd125000000,
    32'd125000001, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF
  };

  spi_clock_divider_search u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .requested_rate_hz_i (in_rate),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .prescale_value_o    (prescale),
    .post_divide_o       (post_divide),
    .actual_rate_hz_o    (actual_rate)
  );

  // Free-running clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results owed.", cycles, sb.pending());
      $display("tb_spi_clock_divider_search failed");
      $finish;
    end
  end

  // Result side backpressure in random bursts.
  always @(posedge clk_i) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every result transfer is checked against the oldest owed setting.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sb.check_result(prescale, post_divide, actual_rate);
    end
  end

  // Requests mostly below the clock, spread over many decades, plus some noise.
  function automatic logic [ClkW-1:0] random_rate(input logic [ClkW-1:0] clk_hz);
    logic [ClkW-1:0] lim;
    logic [ClkW-1:0] span;
    lim  = clk_hz >> $urandom_range(0, 24);
    span = 32'(2 * $urandom_range(2, 128)) * 32'd256;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 4000);
      2: return clk_hz + $urandom_range(0, 3) - 32'd2;
      3: return clk_hz / span + $urandom_range(0, 2) - 32'd1;
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  // Offers one request and waits for its transfer.
  task automatic send_rate(input logic [ClkW-1:0] req);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_rate  <= req;
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(req);
  endtask

  // Holds off new requests until every owed result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Writes the peripheral clock register while the block is idle.
  task automatic write_clock(input logic [ClkW-1:0] hz);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_clock(hz);
  endtask

  // Stimulus: directed requests at the reset clock, then random phases.
  initial begin
    phase_clocks[0] = 32'hFFFF_FFFF;
    phase_clocks[1] = 32'd0;
    phase_clocks[2] = 32'd1;
    phase_clocks[3] = 32'd48000000;
    phase_clocks[4] = $urandom;
    phase_clocks[5] = $urandom_range(1000, 200000000);
    phase_clocks[6] = ClkResetHz;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rates[i]) send_rate(directed_rates[i]);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_clock(phase_clocks[ph]);
      settings++;
      idle_on = (ph != NumPhases - 1);
      repeat (ItemsPerPhase) send_rate(random_rate(sb.clk_hz));
      drain();
    end

    repeat (SettleCycles) @(posedge clk_i);

    $display("Checked %0d results over %0d clock settings, zero and all-ones included.",
             sb.checked, settings);
    $display("%0d requests were above the clock, %0d used the largest prescale, %0d %s",
             sb.above_clock, sb.pre_max, sb.post_one, "had no post divider step.");
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_spi_clock_divider_search passed");
    end else begin
      $display("tb_spi_clock_divider_search failed");
    end
    $finish;
  end

endmodule
